FILE: hdl/drx_pkg.sv
`timescale 1ns / 1ps
package drx_pkg;

  localparam int PAYLOAD_BYTES = 250;

  localparam logic [7:0] SOF_MARK = 8'hAA;
  localparam logic [7:0] EOF_MARK = 8'h55;

  localparam logic [7:0] POS_TYPE    = 8'd1;
  localparam logic [7:0] POS_LENGTH  = 8'd2;
  localparam logic [7:0] POS_PAYLOAD = 8'd3;
  localparam logic [7:0] POS_CHECK   = 8'(3 + PAYLOAD_BYTES);

  localparam logic [7:0] LOWEST_TYPE_RESET    = 8'd1;
  localparam logic [7:0] HIGHEST_TYPE_RESET   = 8'd9;
  localparam logic [7:0] HEARTBEAT_TYPE_RESET = 8'd9;
  localparam logic [7:0] LENGTH_LIMIT_RESET   = 8'd250;

  localparam int ADDR_W = 4;

  typedef enum logic [1:0] {
    REG_LOWEST_TYPE    = 2'd0,
    REG_HIGHEST_TYPE   = 2'd1,
    REG_HEARTBEAT_TYPE = 2'd2,
    REG_LENGTH_LIMIT   = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_END      = 3'd1,
    ERR_TYPE     = 3'd2,
    ERR_LENGTH   = 3'd3,
    ERR_CHECKSUM = 3'd4
  } err_t;

  typedef struct packed {
    logic [7:0] lowest_type;
    logic [7:0] highest_type;
    logic [7:0] heartbeat_type;
    logic [7:0] length_limit;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    logic        frame_end;
    logic        frame_ok;
    err_t        error_kind;
    logic [7:0]  frame_type;
    logic [7:0]  frame_length;
    logic        reply_ack;
    logic [31:0] good_frames;
    logic [31:0] bad_frames;
    logic [31:0] checksum_failures;
  } res_t;

endpackage

FILE: hdl/drx_if.sv
`timescale 1ns / 1ps
interface drx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source(output valid, output rx_byte, input ready);
  modport sink(input valid, input rx_byte, output ready);
endinterface

interface drx_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic [7:0]  byte_index;
  logic        frame_end;
  logic        frame_ok;
  logic [2:0]  error_kind;
  logic [7:0]  frame_type;
  logic [7:0]  frame_length;
  logic        reply_ack;
  logic [31:0] good_frames;
  logic [31:0] bad_frames;
  logic [31:0] checksum_failures;

  modport source(output valid, output data_byte, output byte_index, output frame_end,
                 output frame_ok, output error_kind, output frame_type,
                 output frame_length, output reply_ack, output good_frames,
                 output bad_frames, output checksum_failures, input ready);
  modport sink(input valid, input data_byte, input byte_index, input frame_end,
               input frame_ok, input error_kind, input frame_type,
               input frame_length, input reply_ack, input good_frames,
               input bad_frames, input checksum_failures, output ready);
endinterface

FILE: hdl/delimited_frame_receiver_xor_check.sv
`timescale 1ns / 1ps
// Throughput: one byte per cycle while the two-entry result buffer has room;
// the frame state is updated once per byte in a single registered pass.
// Bytes wait in a staging register and results drain through that buffer.
// Reset (synchronous, active high) returns the receiver to hunting for the
// start byte, clears all counters and restores the register defaults.
module delimited_frame_receiver_xor_check
  import drx_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  drx_in_if.sink            rx,
  drx_out_if.source         res,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t cfg;
  logic push;
  logic push_ready;
  res_t push_data;

  drx_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  drx_core u_core (
    .clk        (clk),
    .rst        (rst),
    .rx         (rx),
    .cfg        (cfg),
    .push_ready (push_ready),
    .push       (push),
    .res        (push_data)
  );

  drx_skid u_skid (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .din        (push_data),
    .push_ready (push_ready),
    .res        (res)
  );

endmodule

FILE: hdl/drx_cfg.sv
`timescale 1ns / 1ps
module drx_cfg
  import drx_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic     wr;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lowest_type    <= LOWEST_TYPE_RESET;
      cfg.highest_type   <= HIGHEST_TYPE_RESET;
      cfg.heartbeat_type <= HEARTBEAT_TYPE_RESET;
      cfg.length_limit   <= LENGTH_LIMIT_RESET;
    end else if (wr) begin
      case (idx)
        REG_LOWEST_TYPE:    cfg.lowest_type    <= pwdata[7:0];
        REG_HIGHEST_TYPE:   cfg.highest_type   <= pwdata[7:0];
        REG_HEARTBEAT_TYPE: cfg.heartbeat_type <= pwdata[7:0];
        REG_LENGTH_LIMIT:   cfg.length_limit   <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_LOWEST_TYPE:    prdata = {24'd0, cfg.lowest_type};
      REG_HIGHEST_TYPE:   prdata = {24'd0, cfg.highest_type};
      REG_HEARTBEAT_TYPE: prdata = {24'd0, cfg.heartbeat_type};
      REG_LENGTH_LIMIT:   prdata = {24'd0, cfg.length_limit};
      default:            prdata = 32'd0;
    endcase
  end

endmodule

FILE: hdl/drx_core.sv
`timescale 1ns / 1ps
module drx_core
  import drx_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  drx_in_if.sink rx,
  input  cfg_t   cfg,
  input  logic   push_ready,
  output logic   push,
  output res_t   res
);

  logic        stg_valid;
  logic [7:0]  stg_byte;
  logic        fire;

  logic        in_frame, in_frame_next;
  logic [7:0]  position, position_next;
  logic [7:0]  running_xor, running_xor_next;
  logic [7:0]  held_type, held_type_next;
  logic [7:0]  held_length, held_length_next;
  logic [7:0]  held_checksum, held_checksum_next;
  logic [31:0] good_count, good_count_next;
  logic [31:0] bad_count, bad_count_next;
  logic [31:0] checksum_count, checksum_count_next;
  err_t        err;
  logic        has_res;

  assign fire     = stg_valid && push_ready;
  assign rx.ready = !stg_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (rx.ready) begin
      stg_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.ready && rx.valid) begin
      stg_byte <= rx.rx_byte;
    end
  end

  always_comb begin
    in_frame_next       = in_frame;
    position_next       = position;
    running_xor_next    = running_xor;
    held_type_next      = held_type;
    held_length_next    = held_length;
    held_checksum_next  = held_checksum;
    good_count_next     = good_count;
    bad_count_next      = bad_count;
    checksum_count_next = checksum_count;
    has_res             = 1'b0;
    err                 = ERR_NONE;
    res.data_byte       = 8'd0;
    res.byte_index      = 8'd0;
    res.frame_end       = 1'b0;
    res.frame_ok        = 1'b0;
    res.reply_ack       = 1'b0;

    if (!in_frame) begin
      if (stg_byte == SOF_MARK) begin
        in_frame_next    = 1'b1;
        position_next    = POS_TYPE;
        running_xor_next = SOF_MARK;
      end
    end else if (position == POS_TYPE) begin
      held_type_next   = stg_byte;
      running_xor_next = running_xor ^ stg_byte;
      position_next    = POS_LENGTH;
    end else if (position == POS_LENGTH) begin
      held_length_next = stg_byte;
      running_xor_next = running_xor ^ stg_byte;
      position_next    = POS_PAYLOAD;
    end else if (position < POS_CHECK) begin
      running_xor_next = running_xor ^ stg_byte;
      position_next    = position + 8'd1;
      has_res          = 1'b1;
      res.data_byte    = stg_byte;
      res.byte_index   = position - POS_PAYLOAD;
    end else if (position == POS_CHECK) begin
      held_checksum_next = stg_byte;
      position_next      = position + 8'd1;
    end else begin
      if (stg_byte != EOF_MARK) begin
        err = ERR_END;
      end else if (held_type < cfg.lowest_type || held_type > cfg.highest_type) begin
        err = ERR_TYPE;
      end else if (held_length > cfg.length_limit) begin
        err = ERR_LENGTH;
      end else if (held_checksum != running_xor) begin
        err = ERR_CHECKSUM;
      end
      if (err == ERR_NONE) begin
        good_count_next = good_count + 32'd1;
        res.reply_ack   = (held_type == cfg.heartbeat_type);
      end else begin
        bad_count_next = bad_count + 32'd1;
        if (err == ERR_CHECKSUM) begin
          checksum_count_next = checksum_count + 32'd1;
        end
      end
      res.frame_end = 1'b1;
      res.frame_ok  = (err == ERR_NONE);
      in_frame_next = 1'b0;
      position_next = 8'd0;
      has_res       = 1'b1;
    end

    res.error_kind        = err;
    res.frame_type        = held_type_next;
    res.frame_length      = held_length_next;
    res.good_frames       = good_count_next;
    res.bad_frames        = bad_count_next;
    res.checksum_failures = checksum_count_next;
  end

  assign push = fire && has_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame       <= 1'b0;
      position       <= 8'd0;
      running_xor    <= 8'd0;
      held_type      <= 8'd0;
      held_length    <= 8'd0;
      held_checksum  <= 8'd0;
      good_count     <= 32'd0;
      bad_count      <= 32'd0;
      checksum_count <= 32'd0;
    end else if (fire) begin
      in_frame       <= in_frame_next;
      position       <= position_next;
      running_xor    <= running_xor_next;
      held_type      <= held_type_next;
      held_length    <= held_length_next;
      held_checksum  <= held_checksum_next;
      good_count     <= good_count_next;
      bad_count      <= bad_count_next;
      checksum_count <= checksum_count_next;
    end
  end

endmodule

FILE: hdl/drx_skid.sv
`timescale 1ns / 1ps
module drx_skid
  import drx_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  res_t     din,
  output logic     push_ready,
  drx_out_if.source res
);

  res_t       e0, e1;
  logic [1:0] count;
  logic       pop;

  assign push_ready = (count != 2'd2);
  assign pop        = (count != 2'd0) && res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push && !pop) begin
      count <= count + 2'd1;
    end else if (pop && !push) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !pop) begin
      if (count == 2'd0) begin
        e0 <= din;
      end else begin
        e1 <= din;
      end
    end else if (pop && !push) begin
      e0 <= e1;
    end else if (pop && push) begin
      if (count == 2'd1) begin
        e0 <= din;
      end else begin
        e0 <= e1;
        e1 <= din;
      end
    end
  end

  assign res.valid             = (count != 2'd0);
  assign res.data_byte         = e0.data_byte;
  assign res.byte_index        = e0.byte_index;
  assign res.frame_end         = e0.frame_end;
  assign res.frame_ok          = e0.frame_ok;
  assign res.error_kind        = e0.error_kind;
  assign res.frame_type        = e0.frame_type;
  assign res.frame_length      = e0.frame_length;
  assign res.reply_ack         = e0.reply_ack;
  assign res.good_frames       = e0.good_frames;
  assign res.bad_frames        = e0.bad_frames;
  assign res.checksum_failures = e0.checksum_failures;

endmodule

FILE: dv/delimited_frame_receiver_xor_check_tb.sv
`timescale 1ns / 1ps
module delimited_frame_receiver_xor_check_tb;
  import drx_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES = 8;
  localparam int ITEM_BUDGET = 1150;

  localparam cfg_t CFG_RESET = '{LOWEST_TYPE_RESET, HIGHEST_TYPE_RESET,
                                 HEARTBEAT_TYPE_RESET, LENGTH_LIMIT_RESET};
  localparam cfg_t CFG_EMPTY = '{8'hFF, 8'h00, 8'h00, 8'hFF};
  localparam cfg_t CFG_OPEN_ZERO = '{8'h00, 8'hFF, 8'h00, 8'h00};

  typedef enum {FILL_ZERO, FILL_ONES, FILL_START, FILL_RAMP, FILL_RANDOM} fill_t;

  typedef struct {
    cfg_t       cfg;
    logic [7:0] ftype;
    logic [7:0] flen;
    fill_t      fill;
    logic [7:0] flip;
    logic [7:0] tail;
    int         lead;
    bit         typed;
    err_t       want_err;
    bit         want_ack;
  } frame_row_t;

  frame_row_t plan [4] = '{
    '{CFG_RESET, 8'd9, 8'd250, FILL_START, 8'h00, EOF_MARK, 3, 1'b1, ERR_NONE, 1'b1},
    '{CFG_EMPTY, 8'd0, 8'd0, FILL_ZERO, 8'h00, EOF_MARK, 0, 1'b1, ERR_TYPE, 1'b0},
    '{CFG_RESET, 8'd4, 8'd17, FILL_RANDOM, 8'h01, EOF_MARK, 1, 1'b1, ERR_CHECKSUM, 1'b0},
    '{CFG_OPEN_ZERO, 8'd128, 8'd1, FILL_RAMP, 8'h80, SOF_MARK, 0, 1'b1, ERR_END, 1'b0}
  };

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  drx_in_if  rx_if ();
  drx_out_if res_if ();

  delimited_frame_receiver_xor_check u_top (
    .clk     (clk),
    .rst     (rst),
    .rx      (rx_if),
    .res     (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Shadow of the receiver: frame tracking, counters and live register values.
  cfg_t        cfg_live = CFG_RESET;
  bit          fr_active = 1'b0;
  logic [7:0]  fr_pos = '0;
  logic [7:0]  fr_xor = '0;
  logic [7:0]  fr_type = '0;
  logic [7:0]  fr_len = '0;
  logic [7:0]  fr_sum = '0;
  logic [31:0] n_good = '0;
  logic [31:0] n_bad = '0;
  logic [31:0] n_sum_err = '0;

  bit          verdict_typed = 1'b0;
  err_t        typed_err = ERR_NONE;
  bit          typed_ack = 1'b0;

  res_t        pending_beats [$];
  logic [7:0]  body [PAYLOAD_BYTES];
  int          mismatches = 0;
  int          items_sent = 0;
  int          in_burst = 0;
  int          out_burst = 0;

  function automatic int pick_gap(inout int burst_left);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      burst_left = $urandom_range(20, 80);
      return 0;
    end
    return $urandom_range(0, 16);
  endfunction

  function automatic logic [7:0] edgy_byte();
    case ($urandom_range(0, 3))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == SOF_MARK);
    return b;
  endfunction

  function automatic cfg_t random_settings();
    cfg_t       c;
    logic [7:0] tmp;
    c.lowest_type = edgy_byte();
    c.highest_type = edgy_byte();
    if (c.lowest_type > c.highest_type && $urandom_range(0, 3) != 0) begin
      tmp = c.lowest_type;
      c.lowest_type = c.highest_type;
      c.highest_type = tmp;
    end
    if ($urandom_range(0, 1) != 0) begin
      c.heartbeat_type = 8'($urandom_range(c.highest_type, c.lowest_type));
    end else begin
      c.heartbeat_type = edgy_byte();
    end
    c.length_limit = edgy_byte();
    return c;
  endfunction

  function void step_receiver(logic [7:0] b);
    res_t beat;
    err_t verdict;
    beat = '0;
    if (!fr_active) begin
      if (b == SOF_MARK) begin
        fr_active = 1'b1;
        fr_pos = POS_TYPE;
        fr_xor = SOF_MARK;
      end
      return;
    end
    if (fr_pos == POS_TYPE) begin
      fr_type = b;
      fr_xor ^= b;
      fr_pos = POS_LENGTH;
      return;
    end
    if (fr_pos == POS_LENGTH) begin
      fr_len = b;
      fr_xor ^= b;
      fr_pos = POS_PAYLOAD;
      return;
    end
    if (fr_pos == POS_CHECK) begin
      fr_sum = b;
      fr_pos++;
      return;
    end
    if (fr_pos < POS_CHECK) begin
      fr_xor ^= b;
      beat.data_byte = b;
      beat.byte_index = fr_pos - POS_PAYLOAD;
      fr_pos++;
    end else begin
      if (b != EOF_MARK) begin
        verdict = ERR_END;
      end else if (fr_type < cfg_live.lowest_type || fr_type > cfg_live.highest_type) begin
        verdict = ERR_TYPE;
      end else if (fr_len > cfg_live.length_limit) begin
        verdict = ERR_LENGTH;
      end else if (fr_sum != fr_xor) begin
        verdict = ERR_CHECKSUM;
      end else begin
        verdict = ERR_NONE;
      end
      if (verdict == ERR_NONE) begin
        n_good++;
        beat.reply_ack = (fr_type == cfg_live.heartbeat_type);
      end else begin
        n_bad++;
        if (verdict == ERR_CHECKSUM) begin
          n_sum_err++;
        end
      end
      beat.frame_end = 1'b1;
      beat.frame_ok = (verdict == ERR_NONE);
      beat.error_kind = verdict;
      if (verdict_typed) begin
        beat.frame_ok = (typed_err == ERR_NONE);
        beat.error_kind = typed_err;
        beat.reply_ack = typed_ack;
        verdict_typed = 1'b0;
      end
      fr_active = 1'b0;
      fr_pos = '0;
    end
    beat.frame_type = fr_type;
    beat.frame_length = fr_len;
    beat.good_frames = n_good;
    beat.bad_frames = n_bad;
    beat.checksum_failures = n_sum_err;
    pending_beats.push_back(beat);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap(in_burst);
    if (gap > 0) begin
      rx_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx_if.valid <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk); while (!rx_if.ready);
    step_receiver(b);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic fill_body(input fill_t f);
    for (int k = 0; k < PAYLOAD_BYTES; k++) begin
      case (f)
        FILL_ZERO: body[k] = 8'h00;
        FILL_ONES: body[k] = 8'hFF;
        FILL_START: body[k] = SOF_MARK;
        FILL_RAMP: body[k] = 8'(k);
        default: body[k] = 8'($urandom_range(0, 255));
      endcase
    end
  endtask

  task automatic send_frame(input logic [7:0] ftype, input logic [7:0] flen,
                            input logic [7:0] flip, input logic [7:0] tail,
                            input bit typed, input err_t werr, input bit wack);
    logic [7:0] sum;
    sum = SOF_MARK ^ ftype ^ flen;
    for (int k = 0; k < PAYLOAD_BYTES; k++) begin
      sum ^= body[k];
    end
    send_byte(SOF_MARK);
    send_byte(ftype);
    send_byte(flen);
    for (int k = 0; k < PAYLOAD_BYTES; k++) begin
      send_byte(body[k]);
    end
    send_byte(sum ^ flip);
    verdict_typed = typed;
    typed_err = werr;
    typed_ack = wack;
    send_byte(tail);
  endtask

  // Finishes any open frame, then holds the sender until every beat is back.
  task automatic drain_results();
    while (fr_active) begin
      send_byte(8'($urandom_range(0, 255)));
    end
    rx_if.valid <= 1'b0;
    while (pending_beats.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [7:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= 32'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_LOWEST_TYPE: cfg_live.lowest_type = value;
      REG_HIGHEST_TYPE: cfg_live.highest_type = value;
      REG_HEARTBEAT_TYPE: cfg_live.heartbeat_type = value;
      REG_LENGTH_LIMIT: cfg_live.length_limit = value;
      default: ;
    endcase
    @(negedge clk);
    penable <= 1'b0;
  endtask

  task automatic apply_settings(input cfg_t c);
    drain_results();
    write_reg(REG_LOWEST_TYPE, c.lowest_type);
    write_reg(REG_HIGHEST_TYPE, c.highest_type);
    write_reg(REG_HEARTBEAT_TYPE, c.heartbeat_type);
    write_reg(REG_LENGTH_LIMIT, c.length_limit);
    psel <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  initial begin : result_sink
    int   gap;
    res_t want;
    res_if.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = pick_gap(out_burst);
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (!res_if.valid);
      if (pending_beats.size() == 0) begin
        $error("result beat arrived with nothing expected");
        mismatches++;
      end else begin
        want = pending_beats.pop_front();
        check_field("data_byte", want.data_byte, res_if.data_byte);
        check_field("byte_index", want.byte_index, res_if.byte_index);
        check_field("frame_end", want.frame_end, res_if.frame_end);
        check_field("frame_ok", want.frame_ok, res_if.frame_ok);
        check_field("error_kind", want.error_kind, res_if.error_kind);
        check_field("frame_type", want.frame_type, res_if.frame_type);
        check_field("frame_length", want.frame_length, res_if.frame_length);
        check_field("reply_ack", want.reply_ack, res_if.reply_ack);
        check_field("good_frames", want.good_frames, res_if.good_frames);
        check_field("bad_frames", want.bad_frames, res_if.bad_frames);
        check_field("checksum_failures", want.checksum_failures,
                    res_if.checksum_failures);
      end
      @(negedge clk);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    int         r;
    logic [7:0] t;
    logic [7:0] l;
    logic [7:0] flip;
    logic [7:0] tail;
    rst = 1'b1;
    rx_if.valid = 1'b0;
    rx_if.rx_byte = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].cfg != cfg_live) begin
        apply_settings(plan[i].cfg);
      end
      repeat (plan[i].lead) send_byte(noise_byte());
      fill_body(plan[i].fill);
      send_frame(plan[i].ftype, plan[i].flen, plan[i].flip, plan[i].tail,
                 plan[i].typed, plan[i].want_err, plan[i].want_ack);
    end

    while (items_sent < ITEM_BUDGET) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
      end else if (r < 12) begin
        drain_results();
      end else begin
        if (r < 50) begin
          apply_settings(random_settings());
        end
        t = edgy_byte();
        if (cfg_live.lowest_type <= cfg_live.highest_type && $urandom_range(0, 3) != 0) begin
          t = 8'($urandom_range(cfg_live.highest_type, cfg_live.lowest_type));
        end
        if ($urandom_range(0, 4) == 0) begin
          t = cfg_live.heartbeat_type;
        end
        l = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(cfg_live.length_limit, 0))
                                        : edgy_byte();
        flip = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
        tail = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : EOF_MARK;
        case ($urandom_range(0, 9))
          0: fill_body(FILL_START);
          1: fill_body(FILL_RAMP);
          2: fill_body(FILL_ONES);
          default: fill_body(FILL_RANDOM);
        endcase
        send_frame(t, l, flip, tail, 1'b0, ERR_NONE, 1'b0);
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_beats.size() != 0) begin
      $error("%0d expected result beats never arrived", pending_beats.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
